/* design/halfwidth_to_fullwidth_katakana_defines.svh */
// assertion macros for the halfwidth to fullwidth katakana converter
`ifndef HALFWIDTH_TO_FULLWIDTH_KATAKANA_DEFINES_SVH
`define HALFWIDTH_TO_FULLWIDTH_KATAKANA_DEFINES_SVH
`ifndef SYNTH
// condition and consequence in the same cycle
`define HWFK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// consequence in the cycle after the condition
`define HWFK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HWFK_ASSERT_SAME(label, ante, cons, msg)
`define HWFK_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/hwfk_pkg.sv */
// shared types, constants and kana table of the katakana converter
package hwfk_pkg;

	localparam logic [15:0] KANA_BASE   = 16'hFF60;
	localparam logic [15:0] KANA_MASK   = 16'hFFE0;
	localparam logic [15:0] KANA_HIGH   = 16'hFF80;
	localparam logic [15:0] MARK_VOICED = 16'hFF9E;
	localparam logic [15:0] MARK_SEMI   = 16'hFF9F;
	localparam logic [15:0] VOICED_LO   = 16'hFF76;
	localparam logic [15:0] VOICED_HI   = 16'hFF84;
	localparam logic [15:0] SEMI_LO     = 16'hFF8A;
	localparam logic [15:0] SEMI_HI     = 16'hFF8E;

	localparam int OFS_W  = 6;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] KANA_TABLE [0:63] = '{
		16'hff60, 16'h3002, 16'h300c, 16'h300d, 16'h3001, 16'h30fb, 16'h30f2, 16'h30a1,
		16'h30a3, 16'h30a5, 16'h30a7, 16'h30a9, 16'h30e3, 16'h30e5, 16'h30e7, 16'h30c3,
		16'h30fc, 16'h30a2, 16'h30a4, 16'h30a6, 16'h30a8, 16'h30aa, 16'h30ab, 16'h30ad,
		16'h30af, 16'h30b1, 16'h30b3, 16'h30b5, 16'h30b7, 16'h30b9, 16'h30bb, 16'h30bd,
		16'h30bf, 16'h30c1, 16'h30c4, 16'h30c6, 16'h30c8, 16'h30ca, 16'h30cb, 16'h30cc,
		16'h30cd, 16'h30ce, 16'h30cf, 16'h30d2, 16'h30d5, 16'h30d8, 16'h30db, 16'h30de,
		16'h30df, 16'h30e0, 16'h30e1, 16'h30e2, 16'h30e4, 16'h30e6, 16'h30e8, 16'h30e9,
		16'h30ea, 16'h30eb, 16'h30ec, 16'h30ed, 16'h30ef, 16'h30f3, 16'h309b, 16'h309c
	};

	// classified item as it travels from front to back
	typedef struct packed {
		logic [15:0]      unit;
		logic             last;
		logic [OFS_W-1:0] offset;
		logic             in_block;
		logic             can_hold;
		logic             can_semi;
		logic             is_voiced;
		logic             is_semi;
	} entry_t;

	// queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// back end status seen by the top level
	typedef struct packed {
		logic held;
		logic deq;
		logic deq_last;
	} bk_stat_t;

endpackage

/* design/hwfk_front.sv */
// front end: classifies each incoming code unit
module hwfk_front (
	input  logic [15:0]     code_unit,
	input  logic            end_of_text,
	output hwfk_pkg::entry_t entry
);

	logic semi_rng;
	logic voiced_rng;

	// range checks for the bases that take sound marks
	always_comb begin
		semi_rng   = (code_unit >= hwfk_pkg::SEMI_LO) && (code_unit <= hwfk_pkg::SEMI_HI);
		voiced_rng = (code_unit >= hwfk_pkg::VOICED_LO) && (code_unit <= hwfk_pkg::VOICED_HI);
	end

	// build the classified item
	always_comb begin
		entry.unit      = code_unit;
		entry.last      = end_of_text;
		entry.offset    = hwfk_pkg::OFS_W'(code_unit - hwfk_pkg::KANA_BASE);
		entry.in_block  = ((code_unit & hwfk_pkg::KANA_MASK) == hwfk_pkg::KANA_BASE) ||
			((code_unit & hwfk_pkg::KANA_MASK) == hwfk_pkg::KANA_HIGH);
		entry.can_hold  = voiced_rng || semi_rng;
		entry.can_semi  = semi_rng;
		entry.is_voiced = (code_unit == hwfk_pkg::MARK_VOICED);
		entry.is_semi   = (code_unit == hwfk_pkg::MARK_SEMI);
	end

endmodule

/* design/hwfk_queue.sv */
// short queue of classified items between front and back
module hwfk_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  hwfk_pkg::entry_t     wr_data,
	input  logic                 rd_en,
	output hwfk_pkg::entry_t     rd_data,
	output hwfk_pkg::q_stat_t    stat
);

	hwfk_pkg::entry_t                 slots_q [hwfk_pkg::QDEPTH];
	logic [hwfk_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [hwfk_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [hwfk_pkg::QCNT_W-1:0]      count_q;
	logic                             do_wr;
	logic                             do_rd;

	// status and qualified strobes
	always_comb begin
		stat.full  = (count_q == hwfk_pkg::QCNT_W'(hwfk_pkg::QDEPTH));
		stat.empty = (count_q == '0);
		do_wr      = wr_en && !stat.full;
		do_rd      = rd_en && !stat.empty;
		rd_data    = slots_q[rd_ptr_q];
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/hwfk_back.sv */
// back end: merges voiced marks, maps units, drives the result register
module hwfk_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hwfk_pkg::entry_t      entry,
	input  logic                  entry_valid,
	output logic                  deq,
	input  logic                  pop,
	output logic                  empty,
	output logic [15:0]           out_unit,
	output logic                  out_last,
	output hwfk_pkg::bk_stat_t    stat
);

	logic                       held_valid_q;
	logic [hwfk_pkg::OFS_W-1:0] held_offset_q;
	logic                       held_semi_q;
	logic                       out_valid_q;
	logic [15:0]                out_unit_q;
	logic                       out_last_q;

	logic                       can_emit;
	logic                       hold_new;
	logic                       emit;
	logic [15:0]                emit_unit;
	logic                       emit_last;
	logic                       held_next;
	logic [15:0]                mapped_held;
	logic [15:0]                mapped_cur;

	// table lookups for the held base and the current item
	always_comb begin
		mapped_held = hwfk_pkg::KANA_TABLE[held_offset_q];
		mapped_cur  = entry.in_block ? hwfk_pkg::KANA_TABLE[entry.offset] : entry.unit;
		hold_new    = !entry.last && entry.can_hold;
		can_emit    = !out_valid_q || pop;
	end

	// decide what the head item does this cycle
	always_comb begin
		deq       = 1'b0;
		emit      = 1'b0;
		emit_unit = mapped_cur;
		emit_last = entry.last;
		held_next = held_valid_q;
		if (entry_valid) begin
			if (held_valid_q) begin
				if (can_emit) begin
					emit = 1'b1;
					if (entry.is_voiced) begin
						emit_unit = mapped_held + 16'd1;
						deq       = 1'b1;
						held_next = 1'b0;
					end else if (entry.is_semi && held_semi_q) begin
						emit_unit = mapped_held + 16'd2;
						deq       = 1'b1;
						held_next = 1'b0;
					end else begin
						// flush the held base; the item stays unless it is held itself
						emit_unit = mapped_held;
						emit_last = 1'b0;
						deq       = hold_new;
						held_next = hold_new;
					end
				end
			end else if (hold_new) begin
				deq       = 1'b1;
				held_next = 1'b1;
			end else if (can_emit) begin
				emit = 1'b1;
				deq  = 1'b1;
			end
		end
	end

	// hold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			held_offset_q <= '0;
			held_semi_q   <= 1'b0;
		end else begin
			held_valid_q <= held_next;
			if (deq && hold_new) begin
				held_offset_q <= entry.offset;
				held_semi_q   <= entry.can_semi;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_unit_q <= emit_unit;
			out_last_q <= emit_last;
		end
	end

	assign empty         = !out_valid_q;
	assign out_unit      = out_unit_q;
	assign out_last      = out_last_q;
	assign stat.held     = held_valid_q;
	assign stat.deq      = deq;
	assign stat.deq_last = entry.last;

endmodule

/* design/halfwidth_to_fullwidth_katakana.sv */
// top level of the halfwidth to fullwidth katakana converter
// path: an item passes the queue and the back end into the result register; a mergeable
//   base waits for the next item before it or its merged form appears
// throughput: one item per cycle while the queue is not full and results are popped; a
//   held base gives no result, and an item that follows it unmerged waits while it is flushed
// reset: clears the four-entry item queue, the held base and the result register
`include "halfwidth_to_fullwidth_katakana_defines.svh"
module halfwidth_to_fullwidth_katakana (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] out_unit,
	output logic        out_last
);

	hwfk_pkg::entry_t   front_entry;
	hwfk_pkg::entry_t   head_entry;
	hwfk_pkg::q_stat_t  q_stat;
	hwfk_pkg::bk_stat_t bk_stat;
	logic               deq;

	// classify incoming items
	hwfk_front u_front (
		.code_unit   (code_unit),
		.end_of_text (end_of_text),
		.entry       (front_entry)
	);

	// decoupling queue
	hwfk_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_entry),
		.rd_en   (deq),
		.rd_data (head_entry),
		.stat    (q_stat)
	);

	// merge and map
	hwfk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (head_entry),
		.entry_valid (!q_stat.empty),
		.deq         (deq),
		.pop         (pop),
		.empty       (empty),
		.out_unit    (out_unit),
		.out_last    (out_last),
		.stat        (bk_stat)
	);

	assign full = q_stat.full;

	// checks
	`HWFK_ASSERT_SAME(a_queue_full_not_empty, q_stat.full, !q_stat.empty, "queue full and empty")
	`HWFK_ASSERT_SAME(a_deq_has_entry, bk_stat.deq, !q_stat.empty, "dequeue from empty queue")
	`HWFK_ASSERT_NEXT(a_last_clears_hold, bk_stat.deq && bk_stat.deq_last, !bk_stat.held, "held at end")

endmodule

/* tb/sv/halfwidth_to_fullwidth_katakana_tb.sv */
// testbench for the halfwidth to fullwidth katakana converter: directed table, random text
`timescale 1ns / 100ps
module halfwidth_to_fullwidth_katakana_tb;

	// halfwidth block and sound mark codes
	localparam logic [15:0] HW_BASE     = 16'hFF60;
	localparam logic [15:0] HW_MASK     = 16'hFFE0;
	localparam logic [15:0] HW_HIGH     = 16'hFF80;
	localparam logic [15:0] MARK_VOICED = 16'hFF9E;
	localparam logic [15:0] MARK_SEMI   = 16'hFF9F;
	localparam logic [15:0] VOICED_LO   = 16'hFF76;
	localparam logic [15:0] VOICED_HI   = 16'hFF84;
	localparam logic [15:0] SEMI_LO     = 16'hFF8A;
	localparam logic [15:0] SEMI_HI     = 16'hFF8E;

	localparam int PHASE_ITEMS = 260;
	localparam int LONG_HOLD   = 40;
	localparam int DRAIN       = 12;
	localparam int LIMIT       = 200000;

	// fullwidth forms of 0xFF60..0xFF9F
	localparam logic [15:0] FULL_KANA [0:63] = '{
		16'hff60, 16'h3002, 16'h300c, 16'h300d, 16'h3001, 16'h30fb, 16'h30f2, 16'h30a1,
		16'h30a3, 16'h30a5, 16'h30a7, 16'h30a9, 16'h30e3, 16'h30e5, 16'h30e7, 16'h30c3,
		16'h30fc, 16'h30a2, 16'h30a4, 16'h30a6, 16'h30a8, 16'h30aa, 16'h30ab, 16'h30ad,
		16'h30af, 16'h30b1, 16'h30b3, 16'h30b5, 16'h30b7, 16'h30b9, 16'h30bb, 16'h30bd,
		16'h30bf, 16'h30c1, 16'h30c4, 16'h30c6, 16'h30c8, 16'h30ca, 16'h30cb, 16'h30cc,
		16'h30cd, 16'h30ce, 16'h30cf, 16'h30d2, 16'h30d5, 16'h30d8, 16'h30db, 16'h30de,
		16'h30df, 16'h30e0, 16'h30e1, 16'h30e2, 16'h30e4, 16'h30e6, 16'h30e8, 16'h30e9,
		16'h30ea, 16'h30eb, 16'h30ec, 16'h30ed, 16'h30ef, 16'h30f3, 16'h309b, 16'h309c
	};

	typedef struct packed {
		logic [15:0] unit;
		logic        last;
	} text_out_t;

	// one directed item; a typed row carries at most one result
	typedef struct packed {
		logic [15:0] unit;
		logic        eot;
		logic        typed;
		logic        has_out;
		logic [15:0] want_unit;
		logic        want_last;
	} text_row_t;

	localparam int NROWS = 27;
	localparam text_row_t TEXT_ROWS [0:NROWS-1] = '{
		'{16'h0000,    1'b1, 1'b1, 1'b1, 16'h0000, 1'b1},
		'{16'hFFFF,    1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1},
		'{HW_BASE,     1'b0, 1'b1, 1'b1, 16'hFF60, 1'b0},
		'{16'hFF61,    1'b0, 1'b1, 1'b1, 16'h3002, 1'b0},
		'{MARK_VOICED, 1'b0, 1'b1, 1'b1, 16'h309B, 1'b0},
		'{MARK_SEMI,   1'b1, 1'b1, 1'b1, 16'h309C, 1'b1},
		'{VOICED_LO,   1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{MARK_VOICED, 1'b1, 1'b1, 1'b1, 16'h30AC, 1'b1},
		'{SEMI_LO,     1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{MARK_SEMI,   1'b0, 1'b1, 1'b1, 16'h30D1, 1'b0},
		'{VOICED_HI,   1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{MARK_SEMI,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{SEMI_HI,     1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{SEMI_HI,     1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'h0041,    1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{VOICED_LO,   1'b1, 1'b1, 1'b1, 16'h30AB, 1'b1},
		'{SEMI_LO,     1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{MARK_VOICED, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{HW_HIGH,     1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'hFF75,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'hFF85,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'hFF89,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'hFF8F,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'hFF5F,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'hFFA0,    1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'hFF77,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{16'h8000,    1'b1, 1'b0, 1'b0, 16'h0000, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [15:0] code_unit = 16'h0000;
	logic        end_of_text = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] out_unit;
	logic        out_last;

	// converter state as predicted
	logic       kana_held;
	logic [5:0] kana_held_ofs;

	text_out_t converted[$];
	text_out_t expected_out[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int long_holds = 0;
	int items_sent = 0;
	int results_seen = 0;
	int voiced_merges = 0;
	int semi_merges = 0;
	int held_flushes = 0;
	int errors = 0;
	int cycles = 0;

	halfwidth_to_fullwidth_katakana dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.code_unit(code_unit),
		.end_of_text(end_of_text),
		.empty(empty),
		.pop(pop),
		.out_unit(out_unit),
		.out_last(out_last)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic in_hw_block(input logic [15:0] u);
		return ((u & HW_MASK) == HW_BASE) || ((u & HW_MASK) == HW_HIGH);
	endfunction

	function automatic logic takes_semi_mark(input logic [15:0] u);
		return u >= SEMI_LO && u <= SEMI_HI;
	endfunction

	function automatic logic takes_voiced_mark(input logic [15:0] u);
		return (u >= VOICED_LO && u <= VOICED_HI) || takes_semi_mark(u);
	endfunction

	function automatic logic [15:0] widen_unit(input logic [15:0] u);
		logic [15:0] d;
		d = u - HW_BASE;
		if (in_hw_block(u))
			return FULL_KANA[d[5:0]];
		return u;
	endfunction

	// converts one accepted unit, appending its fullwidth output to converted
	task automatic convert_unit(input logic [15:0] u, input logic eot);
		logic [15:0] base_unit;
		logic [15:0] base_kana;
		logic [15:0] d;
		bit merged;
		merged = 1'b0;
		if (kana_held) begin
			base_unit = HW_BASE + {10'd0, kana_held_ofs};
			base_kana = FULL_KANA[kana_held_ofs];
			kana_held = 1'b0;
			if (u == MARK_VOICED) begin
				converted.push_back('{base_kana + 16'd1, eot});
				voiced_merges++;
				merged = 1'b1;
			end else if (u == MARK_SEMI && takes_semi_mark(base_unit)) begin
				converted.push_back('{base_kana + 16'd2, eot});
				semi_merges++;
				merged = 1'b1;
			end else begin
				converted.push_back('{base_kana, 1'b0});
				held_flushes++;
			end
		end
		if (!merged) begin
			if (!eot && takes_voiced_mark(u)) begin
				d = u - HW_BASE;
				kana_held = 1'b1;
				kana_held_ofs = d[5:0];
			end else begin
				converted.push_back('{widen_unit(u), eot});
			end
		end
	endtask

	// called just after a falling edge; returns just after the falling edge that
	// follows acceptance, with push still high
	task automatic offer_unit(input logic [15:0] u, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		code_unit <= u;
		end_of_text <= eot;
		do @(posedge clk); while (full);
		convert_unit(u, eot);
		items_sent++;
		@(negedge clk);
	endtask

	// random unit with a bias toward the halfwidth block and the marks
	function automatic logic [15:0] pick_unit();
		int r;
		logic [15:0] u;
		r = $urandom_range(99);
		if (r < 30)
			u = HW_BASE + 16'($urandom_range(63));
		else if (r < 50)
			u = $urandom_range(1) ? VOICED_LO + 16'($urandom_range(14))
				: SEMI_LO + 16'($urandom_range(4));
		else if (r < 70)
			u = $urandom_range(1) ? MARK_VOICED : MARK_SEMI;
		else
			u = 16'($urandom_range(65535));
		return u;
	endfunction

	// one string of base and mark pairs and random units, or a noisy run with random end marks
	task automatic send_text();
		logic [15:0] text[$];
		logic [15:0] u;
		int syllables;
		bit noisy;
		noisy = $urandom_range(99) < 15;
		syllables = $urandom_range(1, 5);
		for (int s = 0; s < syllables; s++) begin
			if ($urandom_range(99) < 45) begin
				u = $urandom_range(2) != 0 ? VOICED_LO + 16'($urandom_range(14))
					: SEMI_LO + 16'($urandom_range(4));
				text.push_back(u);
				if ($urandom_range(99) < 80)
					text.push_back($urandom_range(1) ? MARK_VOICED : MARK_SEMI);
			end else begin
				text.push_back(pick_unit());
			end
		end
		for (int i = 0; i < text.size(); i++) begin
			if (noisy)
				offer_unit(text[i], $urandom_range(3) == 0);
			else
				offer_unit(text[i], i == text.size() - 1);
			expected_out = {expected_out, converted};
			converted.delete();
		end
	endtask

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		text_out_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (expected_out.size() == 0) begin
				$error("unexpected result: out_unit %h out_last %b", out_unit, out_last);
				errors++;
			end else begin
				want = expected_out.pop_front();
				if (out_unit !== want.unit) begin
					$error("out_unit: expected %h, got %h", want.unit, out_unit);
					errors++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %b, got %b", want.last, out_last);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("halfwidth_to_fullwidth_katakana_tb: done, errors");
			$finish;
		end
	end

	// result side: random stalls, and one long hold on request
	initial begin : result_side
		int hold_count;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				for (hold_count = 0; hold_count < LONG_HOLD; hold_count++)
					@(negedge clk);
				hold_req = 1'b0;
				long_holds++;
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// item side: reset, directed table, random phases, drain
	initial begin : item_side
		int target;
		kana_held = 1'b0;
		kana_held_ofs = 6'd0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < NROWS; i++) begin
			offer_unit(TEXT_ROWS[i].unit, TEXT_ROWS[i].eot);
			if (TEXT_ROWS[i].typed) begin
				converted.delete();
				if (TEXT_ROWS[i].has_out)
					expected_out.push_back('{TEXT_ROWS[i].want_unit, TEXT_ROWS[i].want_last});
			end else begin
				expected_out = {expected_out, converted};
				converted.delete();
			end
		end

		// random text under different idle mixes; last phase holds the result side off
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				3: begin send_idle_pct = 25; recv_stall_pct = 25; end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				send_text();
		end

		// close any open string so nothing stays held
		if (kana_held) begin
			offer_unit(16'h0041, 1'b1);
			expected_out = {expected_out, converted};
			converted.delete();
		end
		push <= 1'b0;
		recv_stall_pct = 0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d items and %0d results: %0d voiced and %0d semi-voiced merges,",
			items_sent, results_seen, voiced_merges, semi_merges);
		$display("  %0d unmerged held bases, four idle mixes and %0d long result-side hold(s)",
			held_flushes, long_holds);
		if (errors == 0 && expected_out.size() == 0)
			$display("halfwidth_to_fullwidth_katakana_tb: done, clean");
		else
			$display("halfwidth_to_fullwidth_katakana_tb: done, errors");
		$finish;
	end

endmodule
